// ===== rtl/rv32c_pkg.sv =====
// ----------------------------------------------------------------------------
// rv32c_pkg: shared types and constants of the RV32 subset core
// Holds the action codes, opcode values, stream widths and the execute result.
// ----------------------------------------------------------------------------
`default_nettype none

package rv32c_pkg;

  // What an input word asks the core to do.
  typedef enum logic [1:0] {
    ACT_EXEC  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_REG   = 2'd3
  } action_e;

  localparam logic [6:0]  OPC_ADD   = 7'h33;
  localparam logic [6:0]  OPC_LW    = 7'h03;
  localparam logic [6:0]  OPC_SW    = 7'h23;
  localparam logic [6:0]  OPC_BEQ   = 7'h63;
  localparam logic [6:0]  OPC_JAL   = 7'h6F;
  localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;

  localparam int unsigned S_TDATA_W = 80;
  localparam int unsigned M_TDATA_W = 72;

  // Everything one item does once its operands are known.
  typedef struct packed {
    logic [31:0] pc_next;
    logic        halt_next;
    logic        retired;
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;
    logic        dm_we;
    logic        dm_re;
    logic        rd_load;
    logic [29:0] dm_word;
    logic [31:0] dm_wdata;
    logic [31:0] rval;
  } exec_res_t;

endpackage

`default_nettype wire

// ===== rtl/rv32_subset_single_cycle_core.sv =====
// ----------------------------------------------------------------------------
// rv32_subset_single_cycle_core: RISC-V subset core (ADD, LW, SW, BEQ, JAL)
// Executes one instruction word per input word and reports PC, read data,
// retire and halt status in one output word per input word.
// ----------------------------------------------------------------------------
// After reset the core runs a clearing pass that writes zero to every word
// of the data memory; s_axis_tready stays low until it is done. DATA_WORDS
// must be a power of two, and word addresses wrap modulo DATA_WORDS. An
// input word enters the execute stage, which reads both register operands
// from the synchronous register file; most words move from there straight
// into the output register, so a new word can be taken every cycle while
// the output stream does not stall. A load (LW) or a data-memory readout
// first passes through the memory-read stage, waiting for the synchronous
// data-memory read port, and the next word is taken only as it leaves that
// stage. A register written by one word is forwarded to the next word that
// reads it, so no extra wait is needed there.
`default_nettype none

module rv32_subset_single_cycle_core #(
  parameter int unsigned DATA_WORDS = 256
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Input stream.
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata from bit 0 up: instr_word[31:0], mem_addr[41:32],
  // load_value[73:42], reg_index[78:74], zero padding.
  input  wire logic [rv32c_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // tuser: action[1:0].
  input  wire logic [1:0]                        s_axis_tuser,
  // Output stream.
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // tdata from bit 0 up: pc_after[31:0], read_value[63:32], retired[64],
  // is_halted[65], zero padding.
  output logic      [rv32c_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

  localparam int unsigned AW = $clog2(DATA_WORDS);

  // Architectural state that lives in flops.
  logic [31:0] pc_q;
  logic        halt_q;

  // Execute stage: the accepted word waits here while its operands arrive.
  logic                 s1_vld_q;
  rv32c_pkg::action_e   s1_action_q;
  logic [31:0]          s1_instr_q;
  logic [9:0]           s1_mem_addr_q;
  logic [31:0]          s1_load_value_q;
  rv32c_pkg::exec_res_t s1_res;

  // Memory-read stage: a load or readout waiting for data-memory read data.
  logic       s2_vld_q;
  logic       s2_load_q;
  logic [4:0] s2_rd_q;

  // Output register.
  logic        out_vld_q;
  logic [31:0] out_pc_q, out_rval_q;
  logic        out_ret_q, out_halt_q;

  logic        accept, out_load_ok, s1_go, s1_out, s2_go;
  logic [31:0] op_a, op_b, dm_rdata;
  logic        dm_busy;
  logic        rf_we;
  logic [4:0]  rf_waddr, rf_raddr_a;
  logic [31:0] rf_wdata;

  // The output register can take a new word when it is empty or being read.
  assign out_load_ok = !out_vld_q || m_axis_tready;
  // The memory-read stage is older than anything in the execute stage.
  assign s2_go       = s2_vld_q && out_load_ok;
  // A word that reads data memory moves on into the memory-read stage, which
  // is always empty while the execute stage holds a word.
  assign s1_go       = s1_vld_q && (s1_res.dm_re || out_load_ok);
  assign s1_out      = s1_go && !s1_res.dm_re;

  assign s_axis_tready = !dm_busy
                       && (!s1_vld_q || s1_out)
                       && (!s2_vld_q || s2_go);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Register file: port A reads rs1 or the readout index, port B reads rs2.
  assign rf_raddr_a = (rv32c_pkg::action_e'(s_axis_tuser) == rv32c_pkg::ACT_REG)
                    ? s_axis_tdata[78:74] : s_axis_tdata[19:15];

  // Only one word writes the register file at any edge: the load leaving the
  // memory-read stage or the word leaving the execute stage.
  always_comb begin
    if (s2_go) begin
      rf_we    = s2_load_q;
      rf_waddr = s2_rd_q;
      rf_wdata = dm_rdata;
    end else begin
      rf_we    = s1_go && s1_res.rf_we;
      rf_waddr = s1_res.rf_waddr;
      rf_wdata = s1_res.rf_wdata;
    end
  end

  rv32c_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .re_i      (accept),
    .raddr_a_i (rf_raddr_a),
    .raddr_b_i (s_axis_tdata[24:20]),
    .rdata_a_o (op_a),
    .rdata_b_o (op_b),
    .we_i      (rf_we),
    .waddr_i   (rf_waddr),
    .wdata_i   (rf_wdata)
  );

  rv32c_exec u_exec (
    .action_i     (s1_action_q),
    .instr_i      (s1_instr_q),
    .mem_addr_i   (s1_mem_addr_q),
    .load_value_i (s1_load_value_q),
    .pc_i         (pc_q),
    .halted_i     (halt_q),
    .op_a_i       (op_a),
    .op_b_i       (op_b),
    .res_o        (s1_res)
  );

  // Data-memory reads and writes both happen as a word leaves the execute
  // stage, so they are ordered exactly as the words are.
  rv32c_dmem #(
    .DATA_WORDS (DATA_WORDS)
  ) u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (s1_go && s1_res.dm_we),
    .waddr_i (s1_res.dm_word[AW-1:0]),
    .wdata_i (s1_res.dm_wdata),
    .re_i    (s1_go && s1_res.dm_re),
    .raddr_i (s1_res.dm_word[AW-1:0]),
    .rdata_o (dm_rdata),
    .busy_o  (dm_busy)
  );

  // Payload of the pipeline stages.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_action_q     <= rv32c_pkg::action_e'(s_axis_tuser);
      s1_instr_q      <= s_axis_tdata[31:0];
      s1_mem_addr_q   <= s_axis_tdata[41:32];
      s1_load_value_q <= s_axis_tdata[73:42];
    end
    if (s1_go && s1_res.dm_re) begin
      s2_load_q <= s1_res.rd_load;
      s2_rd_q   <= s1_res.rf_waddr;
    end
    if (s2_go) begin
      out_pc_q   <= pc_q;
      out_rval_q <= s2_load_q ? 32'd0 : dm_rdata;
      out_ret_q  <= s2_load_q;
      out_halt_q <= halt_q;
    end else if (s1_out) begin
      out_pc_q   <= s1_res.pc_next;
      out_rval_q <= s1_res.rval;
      out_ret_q  <= s1_res.retired;
      out_halt_q <= s1_res.halt_next;
    end
  end

  // Control state and the PC and halt flag, which change as a word leaves
  // the execute stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q      <= 32'd0;
      halt_q    <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_go) begin
        pc_q   <= s1_res.pc_next;
        halt_q <= s1_res.halt_next;
      end
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (s1_go) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_go && s1_res.dm_re) begin
        s2_vld_q <= 1'b1;
      end else if (s2_go) begin
        s2_vld_q <= 1'b0;
      end
      if (s2_go || s1_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0, out_halt_q, out_ret_q, out_rval_q, out_pc_q};

  // The execute and memory-read stages never hold words at the same time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_vld_q && s2_vld_q))
    else $error("execute and memory-read stages both occupied");

  // No word is taken while the data memory is still being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !dm_busy)
    else $error("word accepted during data-memory clearing pass");

  // A word that reads data memory is in the memory-read stage next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_res.dm_re) |=> s2_vld_q)
    else $error("memory read lost between stages");

  // Once halted, the core stays halted until reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt flag dropped without reset");

  // A retired instruction never reports the core as halted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_ret_q) |-> !out_halt_q)
    else $error("retired word reports halted core");

endmodule

`default_nettype wire

// ===== rtl/rv32c_regfile.sv =====
// ----------------------------------------------------------------------------
// rv32c_regfile: 32 x 32 register file
// Two synchronous read ports, one write port, write-through on a read of the
// entry written at the same edge, valid bits so that reset reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32c_regfile (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        re_i,
  input  wire logic [4:0]  raddr_a_i,
  input  wire logic [4:0]  raddr_b_i,
  output logic      [31:0] rdata_a_o,
  output logic      [31:0] rdata_b_o,
  input  wire logic        we_i,
  input  wire logic [4:0]  waddr_i,
  input  wire logic [31:0] wdata_i
);

  localparam int unsigned NumRegs = 32;

  logic [31:0]        mem [NumRegs];
  logic [NumRegs-1:0] vld_q;
  logic               wr_ok;
  logic [31:0]        rd_a_q, rd_b_q, byp_data_q;
  logic               ok_a_q, ok_b_q, byp_a_q, byp_b_q;

  // x0 is never written, so it never becomes valid and always reads zero.
  assign wr_ok = we_i && (waddr_i != 5'd0);

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_a_q     <= mem[raddr_a_i];
      rd_b_q     <= mem[raddr_b_i];
      byp_data_q <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      ok_a_q  <= 1'b0;
      ok_b_q  <= 1'b0;
      byp_a_q <= 1'b0;
      byp_b_q <= 1'b0;
    end else begin
      if (wr_ok) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        ok_a_q  <= vld_q[raddr_a_i];
        ok_b_q  <= vld_q[raddr_b_i];
        byp_a_q <= wr_ok && (waddr_i == raddr_a_i);
        byp_b_q <= wr_ok && (waddr_i == raddr_b_i);
      end
    end
  end

  assign rdata_a_o = byp_a_q ? byp_data_q : (ok_a_q ? rd_a_q : 32'd0);
  assign rdata_b_o = byp_b_q ? byp_data_q : (ok_b_q ? rd_b_q : 32'd0);

endmodule

`default_nettype wire

// ===== rtl/rv32c_dmem.sv =====
// ----------------------------------------------------------------------------
// rv32c_dmem: word data memory
// One write port, one synchronous read port, and a clearing pass after reset
// that writes zero to every word, one word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32c_dmem #(
  parameter int unsigned DATA_WORDS = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          we_i,
  input  wire logic [$clog2(DATA_WORDS)-1:0] waddr_i,
  input  wire logic [31:0]                   wdata_i,
  input  wire logic                          re_i,
  input  wire logic [$clog2(DATA_WORDS)-1:0] raddr_i,
  output logic      [31:0]                   rdata_o,
  output logic                               busy_o
);

  localparam int unsigned AW = $clog2(DATA_WORDS);

  logic [31:0]   mem [DATA_WORDS];
  logic [31:0]   rdata_q;
  logic          clr_busy_q;
  logic [AW-1:0] clr_idx_q;

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_idx_q] <= 32'd0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + AW'(1);
      if (clr_idx_q == AW'(DATA_WORDS - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_busy_q;

endmodule

`default_nettype wire

// ===== rtl/rv32c_exec.sv =====
// ----------------------------------------------------------------------------
// rv32c_exec: decode and execute of one item
// Works out the next PC, halt flag, register and memory accesses of an item
// from its fields, the current PC and the two register operands.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32c_exec (
  input  wire rv32c_pkg::action_e action_i,
  input  wire logic [31:0]        instr_i,
  input  wire logic [9:0]         mem_addr_i,
  input  wire logic [31:0]        load_value_i,
  input  wire logic [31:0]        pc_i,
  input  wire logic               halted_i,
  input  wire logic [31:0]        op_a_i,
  input  wire logic [31:0]        op_b_i,
  output rv32c_pkg::exec_res_t    res_o
);

  logic [31:0] imm_i, imm_s, imm_b, imm_j, pc4, ea_load, ea_store;

  assign imm_i    = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s    = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b    = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                     instr_i[11:8], 1'b0};
  assign imm_j    = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                     instr_i[30:21], 1'b0};
  assign pc4      = pc_i + 32'd4;
  assign ea_load  = op_a_i + imm_i;
  assign ea_store = op_a_i + imm_s;

  always_comb begin
    res_o           = '0;
    res_o.pc_next   = pc_i;
    res_o.halt_next = halted_i;
    res_o.rf_waddr  = instr_i[11:7];
    res_o.dm_wdata  = op_b_i;
    unique case (action_i)
      rv32c_pkg::ACT_EXEC: begin
        if (!halted_i) begin
          if (instr_i == rv32c_pkg::HALT_WORD) begin
            res_o.halt_next = 1'b1;
          end else begin
            res_o.pc_next = pc4;
            unique case (instr_i[6:0])
              rv32c_pkg::OPC_ADD: begin
                res_o.retired  = 1'b1;
                res_o.rf_we    = 1'b1;
                res_o.rf_wdata = op_a_i + op_b_i;
              end
              rv32c_pkg::OPC_LW: begin
                res_o.retired = 1'b1;
                res_o.dm_re   = 1'b1;
                res_o.rd_load = 1'b1;
                res_o.dm_word = ea_load[31:2];
              end
              rv32c_pkg::OPC_SW: begin
                res_o.retired = 1'b1;
                res_o.dm_we   = 1'b1;
                res_o.dm_word = ea_store[31:2];
              end
              rv32c_pkg::OPC_BEQ: begin
                res_o.retired = 1'b1;
                res_o.pc_next = (op_a_i == op_b_i) ? pc_i + imm_b : pc4;
              end
              rv32c_pkg::OPC_JAL: begin
                res_o.retired  = 1'b1;
                res_o.rf_we    = 1'b1;
                res_o.rf_wdata = pc4;
                res_o.pc_next  = pc_i + imm_j;
              end
              default: begin
                res_o.retired = 1'b0;
              end
            endcase
          end
        end
      end
      rv32c_pkg::ACT_WRITE: begin
        res_o.dm_we    = 1'b1;
        res_o.dm_word  = {22'd0, mem_addr_i[9:2]};
        res_o.dm_wdata = load_value_i;
      end
      rv32c_pkg::ACT_READ: begin
        res_o.dm_re   = 1'b1;
        res_o.dm_word = {22'd0, mem_addr_i[9:2]};
      end
      rv32c_pkg::ACT_REG: begin
        res_o.rval = op_a_i;
      end
      default: begin
        res_o.rval = 32'd0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the RV32 subset core
// Feeds execute, preload and readout words through the input stream. A
// shadow model of the PC, registers, data memory and halt flag predicts
// every output word, which is then compared field by field.
// ----------------------------------------------------------------------------

module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  // Depth of the data memory; it matches the default of the core.
  localparam int unsigned DATA_WORDS  = 256;
  // Number of random words after the directed opening.
  localparam int unsigned RANDOM_WORDS = 850;
  // Cycles the result side holds off when the long stall is requested.
  localparam int unsigned LONG_HOLD   = 150;
  // Hard ceiling on the run. The slowest legal run (clearing pass, every
  // word behind the longest sender gap and receiver stall) is far below it.
  localparam int unsigned CYCLE_LIMIT = 400000;

  // One input word, split into its fields.
  typedef struct {
    rv32c_pkg::action_e action;
    logic [31:0]        instr;
    logic [9:0]         mem_addr;
    logic [31:0]        load_value;
    logic [4:0]         reg_index;
  } core_item_t;

  // One output word, split into its fields.
  typedef struct {
    logic [31:0] pc_after;
    logic [31:0] read_value;
    logic        retired;
    logic        is_halted;
  } core_result_t;

  // Shadow copy of the architectural state. Every accepted input word is
  // applied to it at once, and the output word it should produce is queued.
  // Output words are matched in order against that queue.
  class core_scoreboard;
    core_result_t expected_results[$];
    bit [31:0]    pc;
    bit [31:0]    regs[32];
    bit [31:0]    dmem[DATA_WORDS];
    bit           halted;
    int unsigned  mismatches;
    int unsigned  n_checked;
    int unsigned  n_exec;
    int unsigned  n_retired;
    int unsigned  n_taken;
    int unsigned  n_preload;
    int unsigned  n_readout;

    function bit [31:0] reg_value(logic [4:0] idx);
      return (idx == 5'd0) ? 32'd0 : regs[idx];
    endfunction

    function void write_reg(logic [4:0] idx, bit [31:0] val);
      if (idx != 5'd0) regs[idx] = val;
    endfunction

    // Byte address to word slot: low two bits dropped, wraps at the depth.
    function int unsigned word_of(bit [31:0] byte_addr);
      return (byte_addr >> 2) % DATA_WORDS;
    endfunction

    function void note_input(core_item_t it);
      core_result_t res;
      logic [31:0]  ins;
      bit [31:0]    a;
      bit [31:0]    b;
      bit [31:0]    imm;
      logic [4:0]   rd;
      res.pc_after   = '0;
      res.read_value = '0;
      res.retired    = 1'b0;
      res.is_halted  = 1'b0;
      ins = it.instr;
      case (it.action)
        rv32c_pkg::ACT_EXEC: begin
          n_exec++;
          // Once halted, execute words change nothing at all.
          if (!halted) begin
            if (ins == rv32c_pkg::HALT_WORD) begin
              halted = 1'b1;
            end else begin
              rd = ins[11:7];
              a  = reg_value(ins[19:15]);
              b  = reg_value(ins[24:20]);
              res.retired = 1'b1;
              case (ins[6:0])
                rv32c_pkg::OPC_ADD: begin
                  write_reg(rd, a + b);
                  pc = pc + 32'd4;
                end
                rv32c_pkg::OPC_LW: begin
                  imm = {{20{ins[31]}}, ins[31:20]};
                  write_reg(rd, dmem[word_of(a + imm)]);
                  pc = pc + 32'd4;
                end
                rv32c_pkg::OPC_SW: begin
                  imm = {{20{ins[31]}}, ins[31:25], ins[11:7]};
                  dmem[word_of(a + imm)] = b;
                  pc = pc + 32'd4;
                end
                rv32c_pkg::OPC_BEQ: begin
                  imm = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
                  if (a == b) begin
                    pc = pc + imm;
                    n_taken++;
                  end else begin
                    pc = pc + 32'd4;
                  end
                end
                rv32c_pkg::OPC_JAL: begin
                  imm = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
                  write_reg(rd, pc + 32'd4);
                  pc = pc + imm;
                end
                default: begin
                  res.retired = 1'b0;
                  pc = pc + 32'd4;
                end
              endcase
              if (res.retired) n_retired++;
            end
          end
        end
        rv32c_pkg::ACT_WRITE: begin
          n_preload++;
          dmem[word_of(32'(it.mem_addr))] = it.load_value;
        end
        rv32c_pkg::ACT_READ: begin
          n_readout++;
          res.read_value = dmem[word_of(32'(it.mem_addr))];
        end
        default: begin
          n_readout++;
          res.read_value = reg_value(it.reg_index);
        end
      endcase
      res.pc_after  = pc;
      res.is_halted = halted;
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [rv32c_pkg::M_TDATA_W-1:0] word);
      core_result_t exp;
      if (expected_results.size() == 0) begin
        $error("result word %h arrived with no expectation pending", word);
        mismatches++;
        return;
      end
      exp = expected_results.pop_front();
      n_checked++;
      if (word[31:0] !== exp.pc_after) begin
        $error("pc_after mismatch: expected %h, actual %h", exp.pc_after, word[31:0]);
        mismatches++;
      end
      if (word[63:32] !== exp.read_value) begin
        $error("read_value mismatch: expected %h, actual %h", exp.read_value, word[63:32]);
        mismatches++;
      end
      if (word[64] !== exp.retired) begin
        $error("retired mismatch: expected %b, actual %b", exp.retired, word[64]);
        mismatches++;
      end
      if (word[65] !== exp.is_halted) begin
        $error("is_halted mismatch: expected %b, actual %b", exp.is_halted, word[65]);
        mismatches++;
      end
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [rv32c_pkg::S_TDATA_W-1:0] s_axis_tdata;
  logic [1:0]                      s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [rv32c_pkg::M_TDATA_W-1:0] m_axis_tdata;

  core_scoreboard board = new;

  // Sender pacing: words go out in bursts; between bursts the valid line
  // drops for a random gap. While no_gaps is set the sender never pauses.
  int unsigned burst_left;
  bit          no_gaps;
  // The stimulus bumps this to ask the result side for one long hold-off.
  int unsigned hold_requests;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rv32_subset_single_cycle_core #(
    .DATA_WORDS (DATA_WORDS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // ---------------------------------------------------------------------------
  // Word builders. Fields that the action does not use are filled with random
  // bits so that every field bit toggles, whatever the mix of actions.
  // ---------------------------------------------------------------------------
  function automatic core_item_t base_item(rv32c_pkg::action_e act);
    core_item_t it;
    it.action     = act;
    it.instr      = $urandom;
    it.mem_addr   = 10'($urandom);
    it.load_value = $urandom;
    it.reg_index  = 5'($urandom);
    return it;
  endfunction

  function automatic core_item_t make_exec(logic [31:0] ins);
    core_item_t it;
    it = base_item(rv32c_pkg::ACT_EXEC);
    it.instr = ins;
    return it;
  endfunction

  function automatic core_item_t make_preload(logic [9:0] addr, logic [31:0] val);
    core_item_t it;
    it = base_item(rv32c_pkg::ACT_WRITE);
    it.mem_addr   = addr;
    it.load_value = val;
    return it;
  endfunction

  function automatic core_item_t make_read(logic [9:0] addr);
    core_item_t it;
    it = base_item(rv32c_pkg::ACT_READ);
    it.mem_addr = addr;
    return it;
  endfunction

  function automatic core_item_t make_reg_read(logic [4:0] idx);
    core_item_t it;
    it = base_item(rv32c_pkg::ACT_REG);
    it.reg_index = idx;
    return it;
  endfunction

  // Instruction encoders. The funct3 and funct7 fields are ignored by the
  // decoder, so they carry random bits.
  function automatic logic [31:0] enc_add(logic [4:0] rd, logic [4:0] rs1, logic [4:0] rs2);
    logic [31:0] junk;
    junk = $urandom;
    return {junk[31:25], rs2, rs1, junk[14:12], rd, rv32c_pkg::OPC_ADD};
  endfunction

  function automatic logic [31:0] enc_lw(logic [4:0] rd, logic [4:0] rs1, logic [11:0] imm);
    logic [31:0] junk;
    junk = $urandom;
    return {imm, rs1, junk[14:12], rd, rv32c_pkg::OPC_LW};
  endfunction

  function automatic logic [31:0] enc_sw(logic [4:0] rs1, logic [4:0] rs2, logic [11:0] imm);
    logic [31:0] junk;
    junk = $urandom;
    return {imm[11:5], rs2, rs1, junk[14:12], imm[4:0], rv32c_pkg::OPC_SW};
  endfunction

  function automatic logic [31:0] enc_beq(logic [4:0] rs1, logic [4:0] rs2, logic [12:0] imm);
    logic [31:0] junk;
    junk = $urandom;
    return {imm[12], imm[10:5], rs2, rs1, junk[14:12], imm[4:1], imm[11],
            rv32c_pkg::OPC_BEQ};
  endfunction

  function automatic logic [31:0] enc_jal(logic [4:0] rd, logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rv32c_pkg::OPC_JAL};
  endfunction

  // Most operands come from a few low registers so that results feed later
  // instructions; the rest reach the whole register file.
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom);
  endfunction

  // Half of the memory offsets are small so that stores and loads meet again.
  function automatic logic [11:0] pick_offset();
    return ($urandom_range(0, 1) != 0) ? 12'($urandom_range(0, 15) * 4) : 12'($urandom);
  endfunction

  // One random word: mostly well-formed instructions with random operands,
  // mixed with preloads, readouts and raw noise words.
  function automatic core_item_t random_item();
    int unsigned pick;
    logic [4:0]  rs1;
    logic [31:0] noise;
    pick = $urandom_range(0, 99);
    rs1  = pick_reg();
    if (pick < 14) begin
      return make_preload(10'($urandom), ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom);
    end else if (pick < 22) begin
      return make_read(10'($urandom));
    end else if (pick < 30) begin
      return make_reg_read(5'($urandom));
    end else if (pick < 38) begin
      // A raw word is almost always an unsupported opcode. The halt word is
      // saved for the closing sequence.
      noise = $urandom;
      if (noise == rv32c_pkg::HALT_WORD) noise[0] = 1'b0;
      return make_exec(noise);
    end else if (pick < 58) begin
      return make_exec(enc_add(pick_reg(), rs1, pick_reg()));
    end else if (pick < 72) begin
      return make_exec(enc_lw(pick_reg(), rs1, pick_offset()));
    end else if (pick < 84) begin
      return make_exec(enc_sw(rs1, pick_reg(), pick_offset()));
    end else if (pick < 94) begin
      // Half of the branches compare a register with itself and are taken.
      return make_exec(enc_beq(rs1, ($urandom_range(0, 1) != 0) ? rs1 : pick_reg(),
                               13'($urandom)));
    end else begin
      return make_exec(enc_jal(pick_reg(), 21'($urandom)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. The word is held on the bus until the core takes it; the
  // handshake is sampled at the rising edge, before the core's own registers
  // move, so the check of s_axis_tready sees the value of the past cycle.
  // Valid is lowered only when a gap follows, which keeps a single update of
  // s_axis_tvalid per time step.
  // ---------------------------------------------------------------------------
  task automatic send_item(input core_item_t it);
    int unsigned gap;
    s_axis_tdata  <= rv32c_pkg::S_TDATA_W'({it.reg_index, it.load_value,
                                            it.mem_addr, it.instr});
    s_axis_tuser  <= it.action;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_input(it);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 && !no_gaps) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stops offering words and waits until every predicted word came back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (board.expected_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Output side. Each accepted output word goes to the scoreboard. The ready
  // line follows one of several moods, switched at random: always ready,
  // mostly ready, coin flips, or a rotating 8-bit pattern. A long hold-off,
  // when requested, overrides all of them.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_mode;
    int unsigned phase_left;
    int unsigned hold_left;
    int unsigned holds_served;
    logic [7:0]  ready_pattern;
    stall_mode    = 0;
    phase_left    = 0;
    hold_left     = 0;
    holds_served  = 0;
    ready_pattern = 8'hFF;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
      if (phase_left == 0) begin
        stall_mode    = $urandom_range(0, 3);
        phase_left    = $urandom_range(20, 200);
        ready_pattern = 8'($urandom);
      end
      phase_left--;
      ready_pattern = {ready_pattern[6:0], ready_pattern[7]};
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          2:       m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= ready_pattern[0];
        endcase
      end
    end
  end

  // The run may not go on forever if the core hangs.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus: a directed opening over the field extremes and corner cases, a
  // long random program, then the halt sequence, which ends execution for
  // good since the core is never reset again.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned n;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= rv32c_pkg::ACT_EXEC;
    burst_left    = 1;
    no_gaps       = 1'b0;
    hold_requests = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The first word waits out the memory clearing pass by the handshake.
    // Readouts right after reset must see zero in x0 and in memory.
    send_item(make_reg_read(5'd0));
    send_item(make_read(10'h3FF));
    // Preloads at both ends of the address range; the low two address bits
    // are ignored, so 0x3FD lands on the same word as 0x3FF.
    send_item(make_preload(10'h000, 32'hFFFF_FFFF));
    send_item(make_preload(10'h3FF, 32'h8000_0001));
    send_item(make_preload(10'h3FD, 32'h1234_5678));
    send_item(make_read(10'h3FC));
    // Loads: a plain one, and a negative offset that wraps to the top word.
    send_item(make_exec(enc_lw(5'd1, 5'd0, 12'h000)));
    send_item(make_exec(enc_lw(5'd2, 5'd0, 12'hFFC)));
    // An add that overflows, and one aimed at x0, which must stay zero.
    send_item(make_exec(enc_add(5'd3, 5'd1, 5'd2)));
    send_item(make_exec(enc_add(5'd0, 5'd1, 5'd1)));
    send_item(make_reg_read(5'd0));
    // Stores at the largest positive and negative offsets, wrapping around.
    send_item(make_exec(enc_sw(5'd1, 5'd3, 12'h7FF)));
    send_item(make_exec(enc_sw(5'd0, 5'd1, 12'h800)));
    send_item(make_exec(enc_lw(5'd4, 5'd0, 12'h800)));
    send_item(make_read(10'h3FC));
    // Branches: taken at the farthest forward offset, not taken at the
    // farthest backward one, and then taken at that backward offset.
    send_item(make_exec(enc_beq(5'd1, 5'd1, 13'h0FFE)));
    send_item(make_exec(enc_beq(5'd1, 5'd2, 13'h1000)));
    send_item(make_exec(enc_beq(5'd0, 5'd0, 13'h1000)));
    // Jumps at both extremes of the offset; the second links into x0.
    send_item(make_exec(enc_jal(5'd5, 21'h0FFFFE)));
    send_item(make_exec(enc_jal(5'd0, 21'h100000)));
    send_item(make_reg_read(5'd5));
    // Unsupported opcodes only move the PC on.
    send_item(make_exec(32'h0000_0013));
    send_item(make_exec(32'h0000_0000));
    send_item(make_reg_read(5'd31));

    for (n = 0; n < RANDOM_WORDS; n++) begin
      // Once, the result side stalls for a long stretch while the sender
      // keeps pushing back to back, so the core fills up and pushes back.
      if (n == 300) begin
        hold_requests++;
        no_gaps = 1'b1;
      end
      if (n == 360) no_gaps = 1'b0;
      // Once, the sender waits for the core to run completely dry.
      if (n == 600) drain_results();
      send_item(random_item());
    end
    drain_results();

    // Halt: the PC freezes, later execute words do nothing (a second halt
    // word included), while preload and readout still work.
    send_item(make_exec(rv32c_pkg::HALT_WORD));
    send_item(make_exec(enc_add(5'd6, 5'd1, 5'd1)));
    send_item(make_preload(10'h004, $urandom));
    send_item(make_read(10'h004));
    send_item(make_reg_read(5'd3));
    send_item(make_exec(rv32c_pkg::HALT_WORD));
    drain_results();
    // The wait below lets any stray output word reach the scoreboard.
    repeat (8) @(posedge clk_i);

    if (board.expected_results.size() != 0) begin
      $error("%0d expected result words never arrived", board.expected_results.size());
      board.mismatches++;
    end
    $display("Covered %0d executes (%0d retired, %0d taken branches), %0d preloads, %0d readouts.",
             board.n_exec, board.n_retired, board.n_taken, board.n_preload, board.n_readout);
    $display("Compared %0d result words; %0d field errors.", board.n_checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
